@@ hdl/asa_pkg.sv @@
// Package with field widths, register indexes and item types for the shelf allocator.
`default_nettype none

package asa_pkg;

    // Widths of the item fields and configuration registers.
    localparam int SIDE_W  = 15;
    localparam int PAD_W   = 8;
    localparam int TOTAL_W = 29;
    localparam int AREA_W  = 2 * SIDE_W;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TEXELS   = 2'd2;

    // Operation codes carried in the input tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register values after reset.
    localparam logic [SIDE_W-1:0] RST_ATLAS_WIDTH  = 15'd4096;
    localparam logic [SIDE_W-1:0] RST_ATLAS_HEIGHT = 15'd4096;
    localparam logic [PAD_W-1:0]  RST_PAD_TEXELS   = 8'd1;

    // Bit offsets of the result fields in the output tdata.
    localparam int RX_LSB = 0;
    localparam int RY_LSB = RX_LSB + SIDE_W;
    localparam int RW_LSB = RY_LSB + SIDE_W;
    localparam int RH_LSB = RW_LSB + SIDE_W;
    localparam int UT_LSB = RH_LSB + SIDE_W;

    // One request item.
    typedef struct packed {
        logic              operation;
        logic [SIDE_W-1:0] content_width;
        logic [SIDE_W-1:0] content_height;
    } t_req;

    // One result item.
    typedef struct packed {
        logic               granted;
        logic [SIDE_W-1:0]  rect_x;
        logic [SIDE_W-1:0]  rect_y;
        logic [SIDE_W-1:0]  rect_width;
        logic [SIDE_W-1:0]  rect_height;
        logic [TOTAL_W-1:0] used_total;
    } t_rsp;

endpackage

`default_nettype wire

@@ hdl/atlas_shelf_allocator_core.sv @@
// Shelf packing allocator that places padded rectangles in a 2D texture atlas.
//
// Each accepted item (allocate or clear) yields exactly one result item. The block
// takes one item per clock cycle in a steady stream while results are taken: an
// item is held in the input register, and the placement logic then writes the
// result register and the shelf cursors in the same cycle. The rate is set by the
// cursor update loop (wrap, vertical check, cursor and used-area update with one
// 15x15 multiply), which is combinational between the cursor registers.
// Configuration writes are always taken and must only occur while
// no item is in flight. Atlas side register values of zero act as one; values above
// MAX_SIDE act as MAX_SIDE.
`default_nettype none

module atlas_shelf_allocator_core #(
    parameter int MAX_SIDE = 16384
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Request stream.
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: content_width [14:0], content_height [29:15], zeros above.
    input  wire  [asa_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // tuser: operation [0].
    input  wire  [0:0]                           s_axis_tuser,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata: rect_x [14:0], rect_y [29:15], rect_width [44:30],
    // rect_height [59:45], used_total [88:60], zeros above.
    output logic [asa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // tuser: granted [0].
    output logic [0:0]                           m_axis_tuser,
    // Configuration write channel.
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [asa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [asa_pkg::SIDE_W-1:0]           i_cfg_data
);

    localparam int SW = asa_pkg::SIDE_W;
    localparam int TW = asa_pkg::TOTAL_W;
    localparam int AW = asa_pkg::AREA_W;
    localparam logic [31:0]   MAX_SIDE_W     = 32'(MAX_SIDE);
    localparam logic [SW-1:0] MAX_SIDE_CLAMP = SW'(MAX_SIDE);
    localparam logic [SW-1:0] SIDE_ONES      = '1;
    localparam logic [TW-1:0] TOTAL_ONES     = '1;

    // Configuration registers.
    logic [SW-1:0]            r_atlas_width;
    logic [SW-1:0]            r_atlas_height;
    logic [asa_pkg::PAD_W-1:0] r_pad;

    // Input register.
    logic          r_in_valid;
    asa_pkg::t_req r_in;

    // Shelf state.
    logic [SW-1:0] r_col, n_col;
    logic [SW-1:0] r_row, n_row;
    logic [SW-1:0] r_shelf, n_shelf;
    logic [TW-1:0] r_used, n_used;

    // Result register.
    logic          r_out_valid;
    asa_pkg::t_rsp r_out, n_out;

    logic out_free;
    logic fire;

    // Handshakes: the result register frees up when empty or being taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width  <= asa_pkg::RST_ATLAS_WIDTH;
            r_atlas_height <= asa_pkg::RST_ATLAS_HEIGHT;
            r_pad          <= asa_pkg::RST_PAD_TEXELS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                asa_pkg::CFG_ATLAS_WIDTH:  r_atlas_width  <= i_cfg_data;
                asa_pkg::CFG_ATLAS_HEIGHT: r_atlas_height <= i_cfg_data;
                asa_pkg::CFG_PAD_TEXELS:   r_pad          <= i_cfg_data[asa_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.operation      <= s_axis_tuser[0];
            r_in.content_width  <= s_axis_tdata[SW-1:0];
            r_in.content_height <= s_axis_tdata[2*SW-1:SW];
        end
    end

    // Placement logic: padding, size checks, shelf wrap, vertical check, update.
    always_comb begin
        logic [SW-1:0] w_eff;
        logic [SW-1:0] h_eff;
        logic [SW:0]   pad2;
        logic [SW:0]   pw;
        logic [SW:0]   ph;
        logic [SW+1:0] col_end;
        logic [SW:0]   next_row;
        logic [SW-1:0] col_a;
        logic [SW-1:0] row_a;
        logic [SW-1:0] shelf_a;
        logic [SW+1:0] row_end;
        logic [AW-1:0] area;
        logic [TW+1:0] total;
        logic          fits;
        logic          ok;

        // Effective atlas sides.
        w_eff = r_atlas_width;
        if (r_atlas_width == '0) begin
            w_eff = SW'(1);
        end else if ({17'd0, r_atlas_width} > MAX_SIDE_W) begin
            w_eff = MAX_SIDE_CLAMP;
        end
        h_eff = r_atlas_height;
        if (r_atlas_height == '0) begin
            h_eff = SW'(1);
        end else if ({17'd0, r_atlas_height} > MAX_SIDE_W) begin
            h_eff = MAX_SIDE_CLAMP;
        end

        // Padded size and the fit against the whole atlas.
        pad2 = {(SW - asa_pkg::PAD_W)'(0), r_pad, 1'b0};
        pw   = {1'b0, r_in.content_width} + pad2;
        ph   = {1'b0, r_in.content_height} + pad2;
        fits = (r_in.content_width != '0) && (r_in.content_height != '0)
            && (pw <= {1'b0, w_eff}) && (ph <= {1'b0, h_eff});

        // Wrap to a new shelf when the row overflows; kept even on refusal.
        col_end  = {2'b00, r_col} + {1'b0, pw};
        next_row = {1'b0, r_row} + {1'b0, r_shelf};
        col_a    = r_col;
        row_a    = r_row;
        shelf_a  = r_shelf;
        if (fits && (col_end > {2'b00, w_eff})) begin
            col_a   = '0;
            row_a   = next_row[SW] ? SIDE_ONES : next_row[SW-1:0];
            shelf_a = '0;
        end

        // Vertical room check and area accumulation.
        row_end = {2'b00, row_a} + {1'b0, ph};
        ok      = fits && (row_end <= {2'b00, h_eff});
        area    = AW'(pw[SW-1:0]) * AW'(ph[SW-1:0]);
        total   = {2'b00, r_used} + {1'b0, area};

        n_col   = col_a;
        n_row   = row_a;
        n_shelf = shelf_a;
        n_used  = r_used;
        n_out   = '0;
        if (r_in.operation == asa_pkg::OP_CLEAR) begin
            n_col   = '0;
            n_row   = '0;
            n_shelf = '0;
            n_used  = '0;
        end else if (ok) begin
            n_out.granted     = 1'b1;
            n_out.rect_x      = col_a + SW'(r_pad);
            n_out.rect_y      = row_a + SW'(r_pad);
            n_out.rect_width  = r_in.content_width;
            n_out.rect_height = r_in.content_height;
            n_col             = col_a + pw[SW-1:0];
            if (ph > {1'b0, shelf_a}) begin
                n_shelf = ph[SW-1:0];
            end
            n_used = (total[TW+1:TW] != 2'b00) ? TOTAL_ONES : total[TW-1:0];
        end
        n_out.used_total = n_used;
    end

    // Shelf state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_shelf     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_shelf <= n_shelf;
                r_used  <= n_used;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Pack the result item onto the output stream.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.granted;
    assign m_axis_tdata  = {7'd0, r_out.used_total, r_out.rect_height, r_out.rect_width,
                            r_out.rect_y, r_out.rect_x};

endmodule

`default_nettype wire

@@ hdl/asa_checker.sv @@
// Port-level checker for the shelf allocator, bound to the top level.
`default_nettype none

module asa_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_m_tvalid,
    input wire                              i_m_tready,
    input wire [asa_pkg::M_TDATA_W-1:0]     i_m_tdata,
    input wire [0:0]                        i_m_tuser
);

    localparam int SW = asa_pkg::SIDE_W;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    // A refused or clear result carries an all-zero rectangle.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[0] |-> i_m_tdata[asa_pkg::UT_LSB-1:0] == '0)
        else $error("refused result with nonzero rectangle");

    // A granted result has a nonempty rectangle and a nonzero used total.
    a_granted_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |->
            i_m_tdata[asa_pkg::RW_LSB +: SW] != '0 && i_m_tdata[asa_pkg::RH_LSB +: SW] != '0
            && i_m_tdata[asa_pkg::UT_LSB +: asa_pkg::TOTAL_W] != '0)
        else $error("granted result with empty rectangle or zero total");

endmodule

bind atlas_shelf_allocator_core asa_checker u_asa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/atlas_shelf_allocator_core_tb.sv @@
// Self-checking testbench for the shelf allocator: directed table, random phases, scoreboard.
module atlas_shelf_allocator_core_tb;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          MAX_REPORTS    = 10;
    localparam int          BURST_LEN      = 40;
    localparam int          NUM_PROBES     = 24;
    localparam int          NUM_PHASES     = 8;
    localparam int          RANDOM_PHASE   = 6;
    localparam int unsigned SIDE_MAX       = 16384;
    localparam logic [asa_pkg::SIDE_W-1:0]  ROW_CAP   = '1;
    localparam logic [asa_pkg::TOTAL_W-1:0] TOTAL_CAP = '1;

    // One row of the directed table: the request and, where it is obvious, the result.
    typedef struct packed {
        logic                       op;
        logic [asa_pkg::SIDE_W-1:0] cw;
        logic [asa_pkg::SIDE_W-1:0] ch;
        logic                       known;
        asa_pkg::t_rsp              want;
    } t_probe;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [asa_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]                    s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [asa_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                    m_axis_tuser;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [asa_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [asa_pkg::SIDE_W-1:0]    i_cfg_data    = '0;

    // Shadow copy of the registers and the packing state.
    logic [asa_pkg::SIDE_W-1:0]  reg_width   = asa_pkg::RST_ATLAS_WIDTH;
    logic [asa_pkg::SIDE_W-1:0]  reg_height  = asa_pkg::RST_ATLAS_HEIGHT;
    logic [asa_pkg::PAD_W-1:0]   reg_pad     = asa_pkg::RST_PAD_TEXELS;
    logic [asa_pkg::SIDE_W-1:0]  shelf_col   = '0;
    logic [asa_pkg::SIDE_W-1:0]  shelf_row   = '0;
    logic [asa_pkg::SIDE_W-1:0]  shelf_tall  = '0;
    logic [asa_pkg::TOTAL_W-1:0] area_used   = '0;

    asa_pkg::t_rsp awaited_placements [$];
    t_probe        probes [NUM_PROBES];
    int            fail_count   = 0;
    int            quiet_cycles = 0;
    int            tx_idle_pct  = 0;
    int            rx_stall_pct = 0;

    always #4 i_clk = ~i_clk;

    atlas_shelf_allocator_core #(
        .MAX_SIDE(SIDE_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // A zero register acts as one texel, anything above the maximum side is clipped.
    function automatic int unsigned clamp_side(logic [asa_pkg::SIDE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > SIDE_MAX)
            return SIDE_MAX;
        return 32'(v);
    endfunction

    // Places one request on the shelves and returns the result it should produce.
    function automatic asa_pkg::t_rsp place_rect(asa_pkg::t_req r);
        asa_pkg::t_rsp   res;
        int unsigned     aw;
        int unsigned     ah;
        int unsigned     pw;
        int unsigned     ph;
        int unsigned     nr;
        longint unsigned sum;
        res = '0;
        aw  = clamp_side(reg_width);
        ah  = clamp_side(reg_height);
        if (r.operation == asa_pkg::OP_CLEAR) begin
            shelf_col  = '0;
            shelf_row  = '0;
            shelf_tall = '0;
            area_used  = '0;
        end else if (r.content_width != '0 && r.content_height != '0) begin
            pw = int'(r.content_width) + 2 * int'(reg_pad);
            ph = int'(r.content_height) + 2 * int'(reg_pad);
            if (pw <= aw && ph <= ah) begin
                // Row overflow wraps to a new shelf; the wrap sticks even on refusal.
                if (int'(shelf_col) + pw > aw) begin
                    nr         = int'(shelf_row) + int'(shelf_tall);
                    shelf_col  = '0;
                    shelf_row  = (nr > int'(ROW_CAP)) ? ROW_CAP : nr[asa_pkg::SIDE_W-1:0];
                    shelf_tall = '0;
                end
                if (int'(shelf_row) + ph <= ah) begin
                    res.granted     = 1'b1;
                    res.rect_x      = shelf_col + asa_pkg::SIDE_W'(reg_pad);
                    res.rect_y      = shelf_row + asa_pkg::SIDE_W'(reg_pad);
                    res.rect_width  = r.content_width;
                    res.rect_height = r.content_height;
                    shelf_col       = shelf_col + pw[asa_pkg::SIDE_W-1:0];
                    if (ph > shelf_tall)
                        shelf_tall = ph[asa_pkg::SIDE_W-1:0];
                    sum       = longint'(area_used) + longint'(pw) * longint'(ph);
                    area_used = (sum > TOTAL_CAP) ? TOTAL_CAP : sum[asa_pkg::TOTAL_W-1:0];
                end
            end
        end
        res.used_total = area_used;
        return res;
    endfunction

    function automatic asa_pkg::t_rsp refusal(logic [asa_pkg::TOTAL_W-1:0] tot);
        asa_pkg::t_rsp res;
        res            = '0;
        res.used_total = tot;
        return res;
    endfunction

    function automatic asa_pkg::t_rsp grant(int unsigned x, int unsigned y, int unsigned w,
                                            int unsigned h,
                                            logic [asa_pkg::TOTAL_W-1:0] tot);
        asa_pkg::t_rsp res;
        res.granted     = 1'b1;
        res.rect_x      = x[asa_pkg::SIDE_W-1:0];
        res.rect_y      = y[asa_pkg::SIDE_W-1:0];
        res.rect_width  = w[asa_pkg::SIDE_W-1:0];
        res.rect_height = h[asa_pkg::SIDE_W-1:0];
        res.used_total  = tot;
        return res;
    endfunction

    // Random request: mostly sizes that fit the current atlas, some exact fits, some noise.
    function automatic asa_pkg::t_req draw_request();
        asa_pkg::t_req r;
        int unsigned   aw;
        int unsigned   ah;
        int unsigned   roll;
        int unsigned   wl;
        int unsigned   hl;
        aw               = clamp_side(reg_width);
        ah               = clamp_side(reg_height);
        roll             = $urandom_range(0, 99);
        r.operation      = asa_pkg::OP_ALLOC;
        r.content_width  = asa_pkg::SIDE_W'($urandom);
        r.content_height = asa_pkg::SIDE_W'($urandom);
        if (roll < 4) begin
            r.operation = asa_pkg::OP_CLEAR;
        end else if (roll < 8) begin
            if ($urandom_range(0, 1) == 1)
                r.content_width = '0;
            else
                r.content_height = '0;
        end else if (roll >= 16) begin
            wl = aw >> $urandom_range(0, 4);
            hl = ah >> $urandom_range(0, 4);
            if (wl == 0)
                wl = 1;
            if (hl == 0)
                hl = 1;
            r.content_width  = asa_pkg::SIDE_W'($urandom_range(1, wl));
            r.content_height = asa_pkg::SIDE_W'($urandom_range(1, hl));
            // A padded width that lands exactly on the right edge.
            if (roll < 20 && aw > 2 * int'(reg_pad))
                r.content_width = asa_pkg::SIDE_W'(aw - 2 * int'(reg_pad));
        end
        return r;
    endfunction

    // Offers one request item, with random idle cycles ahead of it, and predicts its result.
    task automatic push_request(input asa_pkg::t_req r, output asa_pkg::t_rsp predicted);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.content_height, r.content_width};
        s_axis_tuser  <= r.operation;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = place_rect(r);
    endtask

    // Writes one register; the caller lowers the valid after its last write.
    task automatic write_reg(input logic [asa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asa_pkg::SIDE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            asa_pkg::CFG_ATLAS_WIDTH: begin
                reg_width = val;
            end
            asa_pkg::CFG_ATLAS_HEIGHT: begin
                reg_height = val;
            end
            asa_pkg::CFG_PAD_TEXELS: begin
                reg_pad = val[asa_pkg::PAD_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_drained();
        while (awaited_placements.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_field(input string field, input longint unsigned want_v,
                              input longint unsigned got_v);
        if (want_v != got_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch at %0t: %s expected %0d got %0d",
                         $time, field, want_v, got_v);
        end
    endtask

    // Result side: random back-pressure, then compare each item with the oldest prediction.
    always @(posedge i_clk) begin : rsp_check
        asa_pkg::t_rsp got;
        asa_pkg::t_rsp want;
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.granted     = m_axis_tuser[0];
            got.rect_x      = m_axis_tdata[asa_pkg::RX_LSB +: asa_pkg::SIDE_W];
            got.rect_y      = m_axis_tdata[asa_pkg::RY_LSB +: asa_pkg::SIDE_W];
            got.rect_width  = m_axis_tdata[asa_pkg::RW_LSB +: asa_pkg::SIDE_W];
            got.rect_height = m_axis_tdata[asa_pkg::RH_LSB +: asa_pkg::SIDE_W];
            got.used_total  = m_axis_tdata[asa_pkg::UT_LSB +: asa_pkg::TOTAL_W];
            if (awaited_placements.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result item at %0t", $time);
            end else begin
                want = awaited_placements.pop_front();
                flag_field("granted", want.granted, got.granted);
                flag_field("rect_x", want.rect_x, got.rect_x);
                flag_field("rect_y", want.rect_y, got.rect_y);
                flag_field("rect_width", want.rect_width, got.rect_width);
                flag_field("rect_height", want.rect_height, got.rect_height);
                flag_field("used_total", want.used_total, got.used_total);
            end
        end
    end

    // Ends the run when no item moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        logic [asa_pkg::SIDE_W-1:0] phase_w   [NUM_PHASES];
        logic [asa_pkg::SIDE_W-1:0] phase_h   [NUM_PHASES];
        logic [asa_pkg::PAD_W-1:0]  phase_pad [NUM_PHASES];
        int                         phase_items [NUM_PHASES];
        int                         p;
        int                         k;
        int                         sent;
        asa_pkg::t_req              r;
        asa_pkg::t_rsp              predicted;

        // Directed table, walked under the reset configuration (4096 x 4096, pad 1).
        probes = '{
            '{asa_pkg::OP_ALLOC, 15'd0,     15'd5,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd5,     15'd0,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd4095,  15'd1,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd1,     15'd1,     1'b1, grant(1, 1, 1, 1, 9)},
            '{asa_pkg::OP_ALLOC, 15'd32767, 15'd32767, 1'b1, refusal(9)},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd2,     1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd4094,  1'b1, refusal(16393)},
            '{asa_pkg::OP_CLEAR, 15'd32767, 15'd32767, 1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd4094,  1'b1, grant(1, 1, 4094, 4094, 16777216)},
            '{asa_pkg::OP_ALLOC, 15'd1,     15'd1,     1'b1, refusal(16777216)},
            '{asa_pkg::OP_CLEAR, 15'd0,     15'd0,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd16384, 15'd16384, 1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd16385, 15'd1,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd21845, 15'd10922, 1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd10922, 15'd21845, 1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd1000,  15'd10,    1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd1000,  15'd20,    1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd1000,  15'd5,     1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd1093,  15'd7,     1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd4000,  1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd1,     15'd1,     1'b0, '0},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd60,    1'b0, '0},
            '{asa_pkg::OP_CLEAR, 15'd0,     15'd0,     1'b1, refusal(0)},
            '{asa_pkg::OP_ALLOC, 15'd4094,  15'd4094,  1'b1, grant(1, 1, 4094, 4094, 16777216)}
        };

        // Atlas settings for the random phases: nominal, largest, clipped, zero, thin, tiny, random, small.
        phase_w     = '{15'd4096, 15'd16384, 15'd32767, 15'd0, 15'd1,     15'd64, 15'd0, 15'd300};
        phase_h     = '{15'd4096, 15'd16384, 15'd32767, 15'd0, 15'd16384, 15'd48, 15'd0, 15'd200};
        phase_pad   = '{8'd1,     8'd0,      8'd255,    8'd0,  8'd0,      8'd2,   8'd0,  8'd3};
        phase_items = '{120,      120,       120,       30,    100,       130,    130,   130};
        phase_w[RANDOM_PHASE]   = asa_pkg::SIDE_W'($urandom_range(1, SIDE_MAX));
        phase_h[RANDOM_PHASE]   = asa_pkg::SIDE_W'($urandom_range(1, SIDE_MAX));
        phase_pad[RANDOM_PHASE] = asa_pkg::PAD_W'($urandom_range(0, 255));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_PROBES; k++) begin
            r.operation      = probes[k].op;
            r.content_width  = probes[k].cw;
            r.content_height = probes[k].ch;
            push_request(r, predicted);
            awaited_placements.insert(awaited_placements.size(),
                                      probes[k].known ? probes[k].want : predicted);
        end
        s_axis_tvalid <= 1'b0;

        // Random phases; the idling pattern rotates every burst so stalls hit every state.
        sent = 0;
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(asa_pkg::CFG_ATLAS_WIDTH, phase_w[p]);
            write_reg(asa_pkg::CFG_ATLAS_HEIGHT, phase_h[p]);
            write_reg(asa_pkg::CFG_PAD_TEXELS, {7'($urandom), phase_pad[p]});
            i_cfg_valid <= 1'b0;
            for (k = 0; k < phase_items[p]; k++) begin
                case ((sent / BURST_LEN) % 4)
                    0: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 0;
                    end
                    1: begin
                        tx_idle_pct  = 78;
                        rx_stall_pct = 0;
                    end
                    2: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 78;
                    end
                    default: begin
                        tx_idle_pct  = 28;
                        rx_stall_pct = 28;
                    end
                endcase
                push_request(draw_request(), predicted);
                awaited_placements.insert(awaited_placements.size(), predicted);
                sent++;
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
